// ===== hw/rtl/eioc_pkg.sv =====
// Package for the parabolic ease-in/ease-out curve core.
// Holds the fixed field width shared by the interfaces and the top level.
// No dependencies.
package eioc_pkg;
  localparam int FIELD_W = 16;
endpackage

// ===== hw/rtl/eioc_if.sv =====
// Valid/ready stream interfaces for the ease curve core: sample in, result out.
// Depends on eioc_pkg for the field width.
interface eioc_in_if;
  import eioc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] param_u;
  logic [FIELD_W-1:0] ease_in;
  logic [FIELD_W-1:0] ease_out;
  modport source (output valid, param_u, ease_in, ease_out, input ready);
  modport sink (input valid, param_u, ease_in, ease_out, output ready);
endinterface

interface eioc_out_if;
  import eioc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] eased_u;
  modport source (output valid, eased_u, input ready);
  modport sink (input valid, eased_u, output ready);
endinterface

// ===== hw/rtl/eioc_div_cell.sv =====
// One restoring-division cell: every lane develops one quotient bit per cycle while en is high.
// Standalone; carries the divisor and a sideband word to the next cell.
module eioc_div_cell #(
  parameter int LANES = 1,
  parameter int RW    = 8,
  parameter int QW    = 8,
  parameter int SW    = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [LANES-1:0][RW-1:0]  in_rem,
  input  logic [LANES-1:0][QW-1:0]  in_quo,
  input  logic [RW-1:0]             in_den,
  input  logic [SW-1:0]             in_side,
  output logic                      out_valid,
  output logic [LANES-1:0][RW-1:0]  out_rem,
  output logic [LANES-1:0][QW-1:0]  out_quo,
  output logic [RW-1:0]             out_den,
  output logic [SW-1:0]             out_side
);
  logic                     valid_r;
  logic [LANES-1:0][RW-1:0] rem_r, rem_nxt;
  logic [LANES-1:0][QW-1:0] quo_r, quo_nxt;
  logic [RW-1:0]            den_r;
  logic [SW-1:0]            side_r;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [RW-1:0] sh;
      sh = {in_rem[i][RW-2:0], 1'b0};
      if (sh >= in_den) begin
        rem_nxt[i] = sh - in_den;
        quo_nxt[i] = {in_quo[i][QW-2:0], 1'b1};
      end else begin
        rem_nxt[i] = sh;
        quo_nxt[i] = {in_quo[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= in_den;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_den   = den_r;
  assign out_side  = side_r;
endmodule

// ===== hw/rtl/ease_in_out_curve_core.sv =====
// Parabolic ease-in/ease-out curve core: a clamp stage, a chain of FRAC_BITS
// division cells that rescales the ease amounts, a piece-select stage, a multiply
// stage, a chain of FRAC_BITS+1 division cells and an output register.
// It takes one transfer per cycle unless a finished result waits on the output.
// The pipeline holds as a whole only while a finished result waits on the output.
// Synchronous active-low reset clears all valid flags; the data path is not reset.
module ease_in_out_curve_core #(
  parameter int FRAC_BITS = 15
) (
  input  logic clk,
  input  logic rst_n,
  eioc_in_if.sink    in_ch,
  eioc_out_if.source out_ch
);
  import eioc_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int VW  = F + 1;          // values 0..1.0
  localparam int SW2 = F + 2;          // values 0..2.0
  localparam int NRW = F + 2;          // rescale remainder width
  localparam int MRW = 2 * F + 3;      // main remainder width
  localparam int PW  = 2 * SW2;        // raw product width
  localparam int NSW = 3 * VW + 2;     // rescale sideband
  localparam int MSW = VW + 2;         // main sideband
  localparam logic [31:0]  ONE32 = 32'd1 << F;
  localparam logic [VW-1:0] ONE  = VW'(ONE32);
  localparam logic [SW2-1:0] TWO = SW2'(ONE32) << 1;

  // The whole pipeline moves whenever the output register is free or being drained.
  logic en;
  logic out_valid_r;
  logic [FIELD_W-1:0] out_data_r;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 0: clamp the three inputs to 1.0 and form the ease sum.
  logic [31:0] u32, a32, b32;
  logic [VW-1:0] uc, ac, bc;
  assign u32 = 32'(in_ch.param_u);
  assign a32 = 32'(in_ch.ease_in);
  assign b32 = 32'(in_ch.ease_out);
  assign uc = (u32 > ONE32) ? ONE : u32[VW-1:0];
  assign ac = (a32 > ONE32) ? ONE : a32[VW-1:0];
  assign bc = (b32 > ONE32) ? ONE : b32[VW-1:0];

  logic            s0_valid_r;
  logic [VW-1:0]   s0_u_r, s0_a_r, s0_b_r;
  logic [SW2-1:0]  s0_s_r;
  logic            s0_pass_r, s0_norm_r;
  logic [SW2-1:0]  s_sum;
  assign s_sum = SW2'(ac) + SW2'(bc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_u_r    <= uc;
      s0_a_r    <= ac;
      s0_b_r    <= bc;
      s0_s_r    <= s_sum;
      // Endpoints of the parameter, or no easing at all, pass u through.
      s0_pass_r <= (uc == '0) || (uc == ONE) || (s_sum == '0);
      s0_norm_r <= s_sum > SW2'(ONE);
    end
  end

  // Rescale chain: floor(a*1.0/(a+b)) and floor(b*1.0/(a+b)) in two lanes.
  // Since a < a+b when the sum exceeds 1.0 the quotients need no integer part.
  logic             nv   [F+1];
  logic [1:0][NRW-1:0] nrem [F+1];
  logic [1:0][F-1:0]   nquo [F+1];
  logic [NRW-1:0]   nden [F+1];
  logic [NSW-1:0]   nside[F+1];

  assign nv[0]      = s0_valid_r;
  assign nrem[0][0] = NRW'(s0_a_r);
  assign nrem[0][1] = NRW'(s0_b_r);
  assign nquo[0]    = '0;
  assign nden[0]    = s0_s_r;
  assign nside[0]   = {s0_u_r, s0_a_r, s0_b_r, s0_pass_r, s0_norm_r};

  for (genvar g = 0; g < F; g++) begin : g_norm
    eioc_div_cell #(.LANES(2), .RW(NRW), .QW(F), .SW(NSW)) u_cell (
      .clk, .rst_n, .en,
      .in_valid(nv[g]), .in_rem(nrem[g]), .in_quo(nquo[g]),
      .in_den(nden[g]), .in_side(nside[g]),
      .out_valid(nv[g+1]), .out_rem(nrem[g+1]), .out_quo(nquo[g+1]),
      .out_den(nden[g+1]), .out_side(nside[g+1])
    );
  end

  // Stage 1: pick the curve piece and line up numerator and divisor factors.
  logic [VW-1:0] n_u, n_a, n_b, an, bn, v;
  logic          n_pass, n_norm;
  logic [SW2-1:0] d;
  assign {n_u, n_a, n_b, n_pass, n_norm} = nside[F];
  assign an = n_norm ? VW'(nquo[F][0]) : n_a;
  assign bn = n_norm ? VW'(nquo[F][1]) : n_b;
  assign d  = TWO - SW2'(an) - SW2'(bn);
  assign v  = ONE - n_u;

  logic           s1_valid_r, s1_pass_r, s1_out_r;
  logic [VW-1:0]  s1_u_r;
  logic [SW2-1:0] s1_m1_r, s1_m2_r, s1_m3_r, s1_m4_r;
  logic [SW2-1:0] m1, m2, m3, m4;
  logic           piece_out;

  always_comb begin
    piece_out = 1'b0;
    if (n_u < an) begin
      // Ease-in: u^2 / (a*d).
      m1 = SW2'(n_u); m2 = SW2'(n_u); m3 = SW2'(an); m4 = d;
    end else if (n_u < ONE - bn) begin
      // Linear middle: (2u - a) / d.
      m1 = (SW2'(n_u) << 1) - SW2'(an); m2 = SW2'(1); m3 = d; m4 = SW2'(1);
    end else begin
      // Ease-out: 1 - (1-u)^2 / (b*d).
      m1 = SW2'(v); m2 = SW2'(v); m3 = SW2'(bn); m4 = d;
      piece_out = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= nv[F];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_m1_r   <= m1;
      s1_m2_r   <= m2;
      s1_m3_r   <= m3;
      s1_m4_r   <= m4;
      s1_u_r    <= n_u;
      s1_pass_r <= n_pass;
      s1_out_r  <= piece_out;
    end
  end

  // Stage 2: form the numerator and divisor products.
  logic           s2_valid_r;
  logic [MRW-1:0] s2_num_r, s2_den_r;
  logic [MSW-1:0] s2_side_r;
  logic [PW-1:0]  prod_n, prod_d;
  assign prod_n = s1_m1_r * s1_m2_r;
  assign prod_d = s1_m3_r * s1_m4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num_r  <= prod_n[MRW-1:0];
      s2_den_r  <= prod_d[MRW-1:0];
      s2_side_r <= {s1_u_r, s1_pass_r, s1_out_r};
    end
  end

  // Main chain: F+1 fraction bits of num/den; the numerator is always below
  // the divisor, so the quotient has no integer part.
  logic                mv   [F+2];
  logic [0:0][MRW-1:0] mrem [F+2];
  logic [0:0][VW-1:0]  mquo [F+2];
  logic [MRW-1:0]      mden [F+2];
  logic [MSW-1:0]      mside[F+2];

  assign mv[0]      = s2_valid_r;
  assign mrem[0][0] = s2_num_r;
  assign mquo[0]    = '0;
  assign mden[0]    = s2_den_r;
  assign mside[0]   = s2_side_r;

  for (genvar g = 0; g < F + 1; g++) begin : g_main
    eioc_div_cell #(.LANES(1), .RW(MRW), .QW(VW), .SW(MSW)) u_cell (
      .clk, .rst_n, .en,
      .in_valid(mv[g]), .in_rem(mrem[g]), .in_quo(mquo[g]),
      .in_den(mden[g]), .in_side(mside[g]),
      .out_valid(mv[g+1]), .out_rem(mrem[g+1]), .out_quo(mquo[g+1]),
      .out_den(mden[g+1]), .out_side(mside[g+1])
    );
  end

  // Output stage: round half up on the extra quotient bit, finish the ease-out
  // piece, saturate to 1.0 and register.
  logic [VW-1:0]  f_u, q, res;
  logic           f_pass, f_out;
  logic [VW:0]    q_inc;
  logic [31:0]    res32;
  assign {f_u, f_pass, f_out} = mside[F+1];
  assign q_inc = {1'b0, mquo[F+1][0]} + (VW+1)'(1);
  assign q     = q_inc[VW:1];

  always_comb begin
    if (f_pass) begin
      res = f_u;
    end else if (f_out) begin
      res = (q >= ONE) ? '0 : ONE - q;
    end else begin
      res = (q > ONE) ? ONE : q;
    end
  end
  assign res32 = 32'(res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= mv[F+1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res32[FIELD_W-1:0];
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.eased_u = out_data_r;

  // The first stage only picks up a sample from an input transfer.
  a_s0_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    $past(en) && $past(rst_n) && s0_valid_r |-> $past(in_ch.valid))
    else $error("stage 0 valid without an input transfer");

  // After rescaling the ease amounts never sum above 1.0.
  a_ease_sum: assert property (@(posedge clk) disable iff (!rst_n)
    nv[F] && !n_pass |-> (SW2'(an) + SW2'(bn)) <= SW2'(ONE))
    else $error("rescaled ease sum above one");

  // A rounded curve value never exceeds 1.0.
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    mv[F+1] && !f_pass |-> q <= ONE)
    else $error("curve quotient above one");

  // While the output stalls nothing in the pipeline moves.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_data_r) && $stable(s2_num_r))
    else $error("pipeline moved during a stall");
endmodule

// ===== sim/ease_in_out_curve_core_tb.sv =====
// Self-checking testbench for the parabolic ease-in/ease-out curve core.
// Depends on eioc_pkg, the eioc_in_if/eioc_out_if interfaces and the core RTL.
module ease_in_out_curve_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import eioc_pkg::*;

  localparam int FRAC = 15;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam logic [FIELD_W-1:0] ONE_W = FIELD_W'(ONE);
  localparam int LATENCY = 2 * FRAC + 5;
  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  eioc_in_if in_ch ();
  eioc_out_if out_ch ();

  ease_in_out_curve_core #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Expected eased parameters, oldest first.
  logic [FIELD_W-1:0] eased_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int idle_cycles = 0;
  // Idling controls: percent chance of a gap on each side, and a receiver hold-off.
  int send_gap_pct = 12;
  int recv_gap_pct = 12;
  bit recv_hold = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Exact long division giving num * 2^FRAC / den, floored or rounded to nearest.
  function automatic longint unsigned frac_div(longint unsigned num, longint unsigned den,
                                               bit nearest);
    longint unsigned q;
    longint unsigned r;
    if (den == 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    q = num / den;
    r = num % den;
    for (int i = 0; i <= FRAC; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 64'd1;
      end
    end
    if (nearest) q = q + 64'd1;
    return q >> 1;
  endfunction

  function automatic longint unsigned sat_one(longint unsigned v);
    return (v > ONE) ? ONE : v;
  endfunction

  // Predicts the eased parameter for one sample.
  function automatic logic [FIELD_W-1:0] ease_curve(logic [FIELD_W-1:0] pu,
                                                    logic [FIELD_W-1:0] pa,
                                                    logic [FIELD_W-1:0] pb);
    longint unsigned u, a, b, s, d, res, v, t;
    u = sat_one(64'(pu));
    a = sat_one(64'(pa));
    b = sat_one(64'(pb));
    s = a + b;
    if (u == 0 || u == ONE || s == 0) return u[FIELD_W-1:0];
    if (s > ONE) begin
      a = frac_div(a, s, 0);
      b = frac_div(b, s, 0);
    end
    d = 2 * ONE - a - b;
    if (u < a) begin
      res = frac_div(u * u, a * d, 1);
    end else if (u < ONE - b) begin
      res = frac_div(2 * u - a, d, 1);
    end else begin
      v = ONE - u;
      t = frac_div(v * v, b * d, 1);
      res = (t >= ONE) ? 0 : ONE - t;
    end
    res = sat_one(res);
    return res[FIELD_W-1:0];
  endfunction

  // Offers one sample, with an optional random gap before it, and waits for its transfer.
  // Valid stays high after the transfer so back-to-back samples need no gap; a gap
  // or the caller drops it before the next rising edge.
  task automatic send_sample(logic [FIELD_W-1:0] pu, logic [FIELD_W-1:0] pa,
                             logic [FIELD_W-1:0] pb);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.param_u <= pu;
    in_ch.ease_in <= pa;
    in_ch.ease_out <= pb;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    eased_q.push_back(ease_curve(pu, pa, pb));
    sent++;
    @(negedge clk);
  endtask

  // Random field value: mostly in range, sometimes any 16-bit value (possibly above 1.0), exactly 1.0 or zero.
  function automatic logic [FIELD_W-1:0] rand_field();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80) return FIELD_W'($urandom_range(ONE_W));
    if (sel < 90) return FIELD_W'($urandom_range(16'hFFFF));
    if (sel < 95) return ONE_W;
    return '0;
  endfunction

  // The receiver drives ready at the falling edge; a hold keeps it low.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_gap_pct);
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      received++;
      if (eased_q.size() == 0) begin
        $error("eased_u: unexpected result, actual %0d", out_ch.eased_u);
        errors++;
      end else begin
        logic [FIELD_W-1:0] want;
        want = eased_q.pop_front();
        if (out_ch.eased_u !== want) begin
          $error("eased_u: expected %0d, actual %0d", want, out_ch.eased_u);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("Timeout after %0d cycles without a transfer.", HANG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Field extremes, pass-through cases, every curve piece and out-of-range clamping.
  task automatic test_directed();
    send_sample(16'd0, 16'd8192, 16'd8192);
    send_sample(ONE_W, 16'd8192, 16'd8192);
    send_sample(16'd12000, 16'd0, 16'd0);
    send_sample(16'hFFFF, 16'd4000, 16'd4000);
    send_sample(16'd1000, 16'hFFFF, 16'hFFFF);
    send_sample(16'd3000, 16'd8192, 16'd8192);
    send_sample(16'd16384, 16'd8192, 16'd8192);
    send_sample(16'd30000, 16'd8192, 16'd8192);
    send_sample(16'd20000, ONE_W, ONE_W);
    send_sample(16'd20000, ONE_W, 16'd0);
    send_sample(16'd20000, 16'd0, ONE_W);
    send_sample(16'd1, 16'd1, 16'd1);
    send_sample(ONE_W - 16'd1, 16'd1, 16'd1);
    send_sample(ONE_W - 16'd1, 16'd20000, 16'd20000);
    send_sample(16'd1, 16'd20000, 16'd20000);
    send_sample(16'd24576, 16'd16384, 16'd16384);
    send_sample(16'd16384, 16'd32767, 16'd1);
    send_sample(16'h8001, 16'h8001, 16'h8001);
    send_sample(16'd5000, 16'h7FFF, 16'h7FFF);
  endtask

  // Random samples with the given gap percentage on both the send and the receive side.
  task automatic test_random(int count, int gap_pct);
    send_gap_pct = gap_pct;
    recv_gap_pct = gap_pct;
    repeat (count) send_sample(rand_field(), rand_field(), rand_field());
  endtask

  // The receiver holds off while samples keep coming, so the pipeline fills and stalls.
  task automatic test_backpressure();
    send_gap_pct = 0;
    fork
      begin
        recv_hold = 1;
        repeat (HOLD_CYCLES) @(posedge clk);
        recv_hold = 0;
      end
      begin
        repeat (150) send_sample(rand_field(), rand_field(), rand_field());
        in_ch.valid <= 1'b0;
      end
    join
    send_gap_pct = 12;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.param_u = '0;
    in_ch.ease_in = '0;
    in_ch.ease_out = '0;
    out_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(800, 12);
    test_random(400, 0);
    test_backpressure();
    test_random(500, 12);
    in_ch.valid <= 1'b0;
    while (eased_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d samples and %0d results: field extremes, pass-through, all",
             sent, received);
    $display("three curve pieces, clamping, ease rescaling and a long output stall.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
